// ===== rtl/core/ebs_pkg.sv =====
// shared codes and constants for the eyelid blink sequencer
package ebs_pkg;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // request kinds
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_BLINK   = 3'd1;
  localparam logic [2:0] ACT_DOUBLE  = 3'd2;
  localparam logic [2:0] ACT_HOLD    = 3'd3;
  localparam logic [2:0] ACT_RESTART = 3'd4;

  // hold codes
  localparam logic [1:0] HOLD_NONE   = 2'd0;
  localparam logic [1:0] HOLD_OPEN   = 2'd1;
  localparam logic [1:0] HOLD_CLOSED = 2'd2;

  // lid phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CLOSING = 2'd1;
  localparam logic [1:0] PH_CLOSED  = 2'd2;
  localparam logic [1:0] PH_OPENING = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_RATE     = 3'd0;
  localparam logic [2:0] REG_DURATION = 3'd1;
  localparam logic [2:0] REG_AUTO     = 3'd2;
  localparam logic [2:0] REG_SEED     = 3'd3;
  localparam logic [2:0] REG_MIN_GAP  = 3'd4;
  localparam logic [2:0] REG_MAX_GAP  = 3'd5;

  localparam logic [11:0] RATE_MIN     = 12'd26;
  localparam logic [11:0] RATE_MAX     = 12'd2560;
  localparam logic [11:0] RATE_RESET   = 12'd256;
  localparam logic [15:0] DUR_MIN      = 16'd40;
  localparam logic [15:0] DUR_RESET    = 16'd150;
  localparam logic [15:0] MIN_GAP_RST  = 16'd2000;
  localparam logic [15:0] MAX_GAP_RST  = 16'd6000;
  localparam logic [31:0] SEED_DEFAULT = 32'hA5A5A5A5;

endpackage

// ===== rtl/core/eyelid_blink_sequencer_top.sv =====
// eyelid blink sequencer: phase timing, eased openness and random idle gaps
//
// One request is taken at a time; in_tready is high only between requests.
// A tick that moves the lid within the closing or opening phase runs the
// restoring divider that forms the progress fraction one quotient bit per
// cycle. Anything that draws a new idle gap (restart, hold release, end of a
// blink) makes two 32-step passes through the same divider, one for the random
// offset modulo the gap span and one for the scale by the rate; with an empty
// gap range the modulo pass is skipped. After reset the block first draws its
// gap before in_tready rises. A finished result sits in the output register
// until taken, while the next request may already be accepted.
module eyelid_blink_sequencer_top #(
  parameter int OPENNESS_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // elapsed_ms[15:0], hold_mode[17:16]
  input  logic [ebs_pkg::IN_DATA_W-1:0]             in_tdata,
  // action[2:0]
  input  logic [ebs_pkg::IN_USER_W-1:0]             in_tuser,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // openness[OPENNESS_BITS:0], phase, hold_state
  output logic [((OPENNESS_BITS+5+7)/8)*8-1:0]      out_tdata,
  input  logic                                      cfg_we,
  input  logic [ebs_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [ebs_pkg::CFG_DATA_W-1:0]            cfg_wdata
);
  import ebs_pkg::*;

  localparam int OB    = OPENNESS_BITS;
  localparam int OUT_W = ((OB + 5 + 7) / 8) * 8;
  localparam logic [OB:0] ONE = {1'b1, {OB{1'b0}}};
  localparam logic [4:0] STEPS_FULL = 5'd31;
  localparam logic [4:0] STEPS_PROG = 5'(OB - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_EVAL, S_PROG, S_DIV, S_POST, S_EASE, S_SCHED, S_GAP, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_MOD, OP_GAP, OP_PROG
  } div_op_t;

  state_t  state_r;
  div_op_t op_r;
  logic    boot_r;

  // configuration
  logic [11:0] rate_q8_r;
  logic [15:0] dur_r;
  logic        auto_en_r;
  logic [31:0] seed_r;
  logic [15:0] min_gap_r;
  logic [15:0] max_gap_r;

  // sequencer state
  logic [1:0]  phase_r;
  logic [OB:0] openness_r;
  logic [31:0] elapsed_r;
  logic [19:0] gap_r;
  logic [15:0] act_dur_r;
  logic        repeat_r;
  logic [1:0]  hold_r;
  logic [31:0] rng_r;

  // working registers
  logic [15:0] dt_r;
  logic [36:0] e25_r;
  logic [19:0] div_rem_r;
  logic [31:0] div_q_r;
  logic [19:0] div_dvsr_r;
  logic [4:0]  div_cnt_r;
  logic [2*OB+1:0] sq_r;
  logic        lower_r;

  logic        out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  // combinational helpers
  logic [11:0] cfg_rate;
  logic [15:0] cfg_dur;
  logic [32:0] e_sum;
  logic [36:0] e25;
  logic [37:0] e25_plus;
  logic [19:0] d11;
  logic [17:0] d3;
  logic [15:0] span;
  logic [31:0] xs1, xs2, xs3;
  logic [20:0] rem2;
  logic [21:0] diff;
  logic        q_bit;
  logic [19:0] rem_step;
  logic [OB-1:0] t_val;
  logic [OB:0] om;
  logic [OB:0] sq_in;
  logic [OB:0] ease_lo, ease_hi, ease;
  logic [15:0] base;
  logic [31:0] seed_eff;
  logic        out_load;

  always_comb begin
    cfg_rate = cfg_wdata[11:0];
    if (cfg_rate < RATE_MIN) begin
      cfg_rate = RATE_MIN;
    end else if (cfg_rate > RATE_MAX) begin
      cfg_rate = RATE_MAX;
    end
    cfg_dur = (cfg_wdata[15:0] < DUR_MIN) ? DUR_MIN : cfg_wdata[15:0];

    e_sum    = {1'b0, elapsed_r} + {17'b0, dt_r};
    e25      = {1'b0, elapsed_r, 4'b0} + {2'b0, elapsed_r, 3'b0} + {5'b0, elapsed_r};
    e25_plus = {1'b0, e25_r} + 38'd25;
    d11      = {1'b0, act_dur_r, 3'b0} + {3'b0, act_dur_r, 1'b0} + {4'b0, act_dur_r};
    d3       = {1'b0, act_dur_r, 1'b0} + {2'b0, act_dur_r};
    span     = (max_gap_r > min_gap_r) ? (max_gap_r - min_gap_r) : 16'd0;
    seed_eff = (seed_r != 32'd0) ? seed_r : SEED_DEFAULT;

    xs1 = rng_r ^ (rng_r << 13);
    xs2 = xs1 ^ (xs1 >> 17);
    xs3 = xs2 ^ (xs2 << 5);

    // one restoring division step
    rem2     = {div_rem_r, div_q_r[31]};
    diff     = {1'b0, rem2} - {2'b0, div_dvsr_r};
    q_bit    = ~diff[21];
    rem_step = q_bit ? diff[19:0] : rem2[19:0];

    // ease in/out quadratic
    t_val   = div_q_r[OB-1:0];
    om      = ONE - {1'b0, t_val};
    sq_in   = t_val[OB-1] ? {om[OB-1:0], 1'b0} : {1'b0, t_val};
    ease_lo = sq_r[OB-1 +: OB+1];
    ease_hi = ONE - sq_r[OB+1 +: OB+1];
    ease    = lower_r ? ease_lo : ease_hi;

    base = min_gap_r + div_rem_r[15:0];

    out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SCHED;
      op_r         <= OP_MOD;
      boot_r       <= 1'b1;
      rate_q8_r    <= RATE_RESET;
      dur_r        <= DUR_RESET;
      auto_en_r    <= 1'b1;
      seed_r       <= 32'd0;
      min_gap_r    <= MIN_GAP_RST;
      max_gap_r    <= MAX_GAP_RST;
      phase_r      <= PH_IDLE;
      openness_r   <= ONE;
      elapsed_r    <= 32'd0;
      gap_r        <= 20'd0;
      act_dur_r    <= DUR_RESET;
      repeat_r     <= 1'b0;
      hold_r       <= HOLD_NONE;
      rng_r        <= SEED_DEFAULT;
      div_cnt_r    <= 5'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RATE:     rate_q8_r <= cfg_rate;
          REG_DURATION: dur_r     <= cfg_dur;
          REG_AUTO:     auto_en_r <= cfg_wdata[0];
          REG_SEED:     seed_r    <= cfg_wdata;
          REG_MIN_GAP:  min_gap_r <= cfg_wdata[15:0];
          REG_MAX_GAP:  max_gap_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= OUT_W'({hold_r, phase_r, openness_r});
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            unique case (in_tuser) inside
              ACT_TICK: begin
                dt_r    <= in_tdata[15:0];
                state_r <= S_TICK;
              end
              ACT_BLINK, ACT_DOUBLE: begin
                if (hold_r == HOLD_NONE) begin
                  act_dur_r <= dur_r;
                  repeat_r  <= (in_tuser == ACT_DOUBLE);
                  phase_r   <= PH_CLOSING;
                  elapsed_r <= 32'd0;
                end
                state_r <= S_DONE;
              end
              ACT_HOLD: begin
                if (in_tdata[17:16] == HOLD_OPEN) begin
                  hold_r     <= HOLD_OPEN;
                  openness_r <= ONE;
                  phase_r    <= PH_IDLE;
                  state_r    <= S_DONE;
                end else if (in_tdata[17:16] == HOLD_CLOSED) begin
                  hold_r     <= HOLD_CLOSED;
                  openness_r <= '0;
                  phase_r    <= PH_IDLE;
                  state_r    <= S_DONE;
                end else begin
                  hold_r     <= HOLD_NONE;
                  openness_r <= ONE;
                  state_r    <= S_SCHED;
                end
              end
              ACT_RESTART: begin
                rng_r      <= seed_eff;
                openness_r <= ONE;
                phase_r    <= PH_IDLE;
                repeat_r   <= 1'b0;
                hold_r     <= HOLD_NONE;
                state_r    <= S_SCHED;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end

        S_TICK: begin
          if (hold_r == HOLD_OPEN) begin
            openness_r <= ONE;
            state_r    <= S_DONE;
          end else if (hold_r == HOLD_CLOSED) begin
            openness_r <= '0;
            state_r    <= S_DONE;
          end else begin
            elapsed_r <= e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
            state_r   <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (phase_r == PH_IDLE) begin
            if (auto_en_r && (elapsed_r >= {12'd0, gap_r})) begin
              act_dur_r <= dur_r;
              repeat_r  <= 1'b0;
              phase_r   <= PH_CLOSING;
              elapsed_r <= 32'd0;
            end
            state_r <= S_DONE;
          end else begin
            e25_r   <= e25;
            state_r <= S_PROG;
          end
        end

        S_PROG: begin
          if (phase_r == PH_CLOSED) begin
            openness_r <= '0;
            if (e25_plus > {20'd0, d3}) begin
              phase_r   <= PH_OPENING;
              elapsed_r <= 32'd0;
            end
            state_r <= S_DONE;
          end else if (e25_r >= {17'd0, d11}) begin
            elapsed_r <= 32'd0;
            if (phase_r == PH_CLOSING) begin
              openness_r <= '0;
              phase_r    <= PH_CLOSED;
              state_r    <= S_DONE;
            end else begin
              openness_r <= ONE;
              if (repeat_r) begin
                repeat_r <= 1'b0;
                phase_r  <= PH_CLOSING;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_SCHED;
              end
            end
          end else begin
            div_rem_r  <= e25_r[19:0];
            div_q_r    <= 32'd0;
            div_dvsr_r <= d11;
            div_cnt_r  <= STEPS_PROG;
            op_r       <= OP_PROG;
            state_r    <= S_DIV;
          end
        end

        S_DIV: begin
          div_rem_r <= rem_step;
          div_q_r   <= {div_q_r[30:0], q_bit};
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd0) begin
            state_r <= S_POST;
          end
        end

        S_POST: begin
          unique case (op_r)
            OP_MOD: state_r <= S_GAP;
            OP_GAP: begin
              gap_r     <= div_q_r[19:0];
              elapsed_r <= 32'd0;
              phase_r   <= PH_IDLE;
              boot_r    <= 1'b0;
              state_r   <= boot_r ? S_IDLE : S_DONE;
            end
            default: begin
              sq_r    <= sq_in * sq_in;
              lower_r <= ~t_val[OB-1];
              state_r <= S_EASE;
            end
          endcase
        end

        S_EASE: begin
          openness_r <= (phase_r == PH_CLOSING) ? (ONE - ease) : ease;
          state_r    <= S_DONE;
        end

        S_SCHED: begin
          if (span != 16'd0) begin
            rng_r      <= xs3;
            div_rem_r  <= 20'd0;
            div_q_r    <= xs3;
            div_dvsr_r <= {4'd0, span};
            div_cnt_r  <= STEPS_FULL;
            op_r       <= OP_MOD;
            state_r    <= S_DIV;
          end else begin
            div_rem_r <= 20'd0;
            state_r   <= S_GAP;
          end
        end

        S_GAP: begin
          div_rem_r  <= 20'd0;
          div_q_r    <= {8'd0, base, 8'd0};
          div_dvsr_r <= {8'd0, rate_q8_r};
          div_cnt_r  <= STEPS_FULL;
          op_r       <= OP_GAP;
          state_r    <= S_DIV;
        end

        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ebs_checker.sv =====
// port-level checks for the eyelid blink sequencer, bound to the top level
module ebs_checker #(
  parameter int OPENNESS_BITS = 16
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((OPENNESS_BITS+5+7)/8)*8-1:0] out_tdata
);
  import ebs_pkg::*;

  localparam int OB = OPENNESS_BITS;
  localparam logic [OB:0] ONE = {1'b1, {OB{1'b0}}};

  logic [OB:0] openness;
  logic [1:0]  phase;
  logic [1:0]  hold_state;

  assign openness   = out_tdata[OB:0];
  assign phase      = out_tdata[OB+2:OB+1];
  assign hold_state = out_tdata[OB+4:OB+3];

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_open_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> openness <= ONE && hold_state != 2'd3)
    else $error("openness or hold code out of range");

  a_closed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hold_state == HOLD_CLOSED |-> openness == '0 && phase == PH_IDLE)
    else $error("closed hold shows an open lid or a running blink");

  a_open_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hold_state == HOLD_OPEN |-> openness == ONE && phase == PH_IDLE)
    else $error("open hold shows a moving lid");

endmodule

bind eyelid_blink_sequencer_top ebs_checker #(
  .OPENNESS_BITS(OPENNESS_BITS)
) u_ebs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/eyelid_blink_sequencer_top_tb.sv =====
// self-checking testbench for the eyelid blink sequencer with a built-in predictor
module eyelid_blink_sequencer_top_tb;
  import ebs_pkg::*;

  localparam int OB = 16;
  localparam int OUT_W = ((OB + 5 + 7) / 8) * 8;
  localparam longint unsigned ONE = 64'd1 << OB;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int LONG_TICKS = 40;

  typedef struct packed {
    logic [OB:0] lid;
    logic [1:0]  phase;
    logic [1:0]  hold;
  } lid_view_t;

  class blink_scoreboard;
    bit [11:0] rate;
    bit [15:0] dur;
    bit        auto_on;
    bit [31:0] seed;
    bit [15:0] gap_lo;
    bit [15:0] gap_hi;
    bit [1:0]  phase;
    bit [1:0]  hold;
    bit [OB:0] lid;
    bit [31:0] ms;
    bit [31:0] gap;
    bit [31:0] rng;
    bit [15:0] run_dur;
    bit        again;
    lid_view_t lid_q[$];
    int        errors;

    function new();
      rate = RATE_RESET;
      dur = DUR_RESET;
      auto_on = 1'b1;
      seed = '0;
      gap_lo = MIN_GAP_RST;
      gap_hi = MAX_GAP_RST;
      phase = PH_IDLE;
      hold = HOLD_NONE;
      lid = (OB+1)'(ONE);
      ms = '0;
      gap = '0;
      rng = SEED_DEFAULT;
      run_dur = DUR_RESET;
      again = 1'b0;
      errors = 0;
      restart_lid();
    endfunction

    function int pending();
      return lid_q.size();
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] val);
      case (idx)
        REG_RATE: begin
          if (val[11:0] < RATE_MIN) rate = RATE_MIN;
          else if (val[11:0] > RATE_MAX) rate = RATE_MAX;
          else rate = val[11:0];
        end
        REG_DURATION: dur = (val[15:0] < DUR_MIN) ? DUR_MIN : val[15:0];
        REG_AUTO:     auto_on = val[0];
        REG_SEED:     seed = val;
        REG_MIN_GAP:  gap_lo = val[15:0];
        REG_MAX_GAP:  gap_hi = val[15:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] advance_rng();
      bit [31:0] r;
      r = rng;
      r ^= r << 13;
      r ^= r >> 17;
      r ^= r << 5;
      rng = r;
      return r;
    endfunction

    function void draw_gap();
      bit [31:0] span;
      bit [31:0] base;
      longint unsigned scaled;
      span = (gap_hi > gap_lo) ? 32'(gap_hi - gap_lo) : 32'd0;
      base = 32'(gap_lo);
      if (span != 0) base += advance_rng() % span;
      scaled = (64'(base) * 64'd256) / 64'(rate);
      gap = 32'(scaled);
      ms = '0;
      phase = PH_IDLE;
    endfunction

    function void begin_blink(bit twice);
      run_dur = dur;
      again = twice;
      phase = PH_CLOSING;
      ms = '0;
    endfunction

    function void restart_lid();
      rng = (seed != 0) ? seed : SEED_DEFAULT;
      lid = (OB+1)'(ONE);
      phase = PH_IDLE;
      again = 1'b0;
      hold = HOLD_NONE;
      draw_gap();
    endfunction

    function longint unsigned ramp(bit [31:0] e, bit [15:0] d);
      longint unsigned dd;
      dd = (d < DUR_MIN) ? 64'(DUR_MIN) : 64'(d);
      if (64'(e) * 25 >= dd * 11) return ONE;
      return (64'(e) * 25 * ONE) / (dd * 11);
    endfunction

    function longint unsigned eased(longint unsigned t);
      longint unsigned f;
      if (t < ONE / 2) return (2 * t * t) >> OB;
      f = 2 * ONE - 2 * t;
      return ONE - ((f * f) >> (OB + 1));
    endfunction

    function void tick_lid(bit [15:0] dt);
      longint unsigned t;
      longint unsigned sum;
      if (hold == HOLD_OPEN) begin
        lid = (OB+1)'(ONE);
        return;
      end
      if (hold == HOLD_CLOSED) begin
        lid = '0;
        return;
      end
      sum = 64'(ms) + 64'(dt);
      ms = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
      case (phase)
        PH_IDLE: begin
          if (auto_on && ms >= gap) begin_blink(1'b0);
        end
        PH_CLOSING: begin
          t = ramp(ms, run_dur);
          lid = (OB+1)'(ONE - eased(t));
          if (t >= ONE) begin
            phase = PH_CLOSED;
            ms = '0;
          end
        end
        PH_CLOSED: begin
          lid = '0;
          if (ms >= (32'(run_dur) * 3) / 25) begin
            phase = PH_OPENING;
            ms = '0;
          end
        end
        default: begin
          t = ramp(ms, run_dur);
          lid = (OB+1)'(eased(t));
          if (t >= ONE) begin
            lid = (OB+1)'(ONE);
            if (again) begin
              again = 1'b0;
              phase = PH_CLOSING;
              ms = '0;
            end else begin
              draw_gap();
            end
          end
        end
      endcase
    endfunction

    function void set_hold(bit [1:0] mode);
      if (mode == HOLD_OPEN) begin
        hold = HOLD_OPEN;
        lid = (OB+1)'(ONE);
        phase = PH_IDLE;
      end else if (mode == HOLD_CLOSED) begin
        hold = HOLD_CLOSED;
        lid = '0;
        phase = PH_IDLE;
      end else begin
        hold = HOLD_NONE;
        lid = (OB+1)'(ONE);
        draw_gap();
      end
    endfunction

    function void note_request(bit [2:0] act, bit [15:0] dt, bit [1:0] mode);
      lid_view_t v;
      case (act)
        ACT_TICK:    tick_lid(dt);
        ACT_BLINK:   if (hold == HOLD_NONE) begin_blink(1'b0);
        ACT_DOUBLE:  if (hold == HOLD_NONE) begin_blink(1'b1);
        ACT_HOLD:    set_hold(mode);
        ACT_RESTART: restart_lid();
        default: ;
      endcase
      v.lid = lid;
      v.phase = phase;
      v.hold = hold;
      lid_q.push_back(v);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      lid_view_t want;
      lid_view_t got;
      got.lid = data[OB:0];
      got.phase = data[OB+2:OB+1];
      got.hold = data[OB+4:OB+3];
      if (lid_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: openness %h phase %0d hold %0d",
                   got.lid, got.phase, got.hold);
        return;
      end
      want = lid_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: openness exp %h got %h, phase exp %0d got %0d, hold exp %0d got %0d",
                   want.lid, got.lid, want.phase, got.phase, want.hold, got.hold);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  blink_scoreboard sb;
  bit              quiet;
  longint          cycles = 0;

  eyelid_blink_sequencer_top #(
    .OPENNESS_BITS(OB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("eyelid_blink_sequencer_top_tb failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'($urandom_range(0, sb.dur / 10 + 2));
    if (r < 75) return 16'($urandom_range(0, 30));
    if (r < 93) return 16'($urandom_range(0, 3000));
    return 16'($urandom);
  endfunction

  // result side with random back-pressure
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (stall > 0 && !quiet) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        stall = 0;
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  task automatic send_request(logic [2:0] act, logic [15:0] dt, logic [1:0] mode);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-18){1'b0}}, mode, dt};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, dt, mode);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || !in_tready);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] rate, logic [31:0] dur, logic [31:0] auto_on,
                           logic [31:0] seed, logic [31:0] lo, logic [31:0] hi);
    wait_idle();
    set_reg(REG_RATE, rate);
    set_reg(REG_DURATION, dur);
    set_reg(REG_AUTO, auto_on);
    set_reg(REG_SEED, seed);
    set_reg(REG_MIN_GAP, lo);
    set_reg(REG_MAX_GAP, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_request(ACT_RESTART, 16'($urandom), 2'($urandom));
  endtask

  task automatic random_request();
    int r;
    logic [2:0] act;
    logic [15:0] dt;
    logic [1:0] mode;
    r = $urandom_range(0, 99);
    dt = 16'($urandom);
    mode = 2'($urandom);
    if (r < 70) begin
      act = ACT_TICK;
      dt = pick_ms();
    end else if (r < 78) begin
      act = ACT_BLINK;
    end else if (r < 84) begin
      act = ACT_DOUBLE;
    end else if (r < 93) begin
      act = ACT_HOLD;
      if ($urandom_range(0, 1)) mode = HOLD_NONE;
    end else if (r < 96) begin
      act = ACT_RESTART;
    end else begin
      act = ACT_RESTART + 3'($urandom_range(1, 3));
    end
    send_request(act, dt, mode);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 2) drain();
      random_request();
    end
    quiet = 1'b0;
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests with reset settings
    send_request(ACT_TICK, 16'd0, HOLD_NONE);
    send_request(ACT_RESTART + 3'd1, 16'hFFFF, HOLD_OPEN | HOLD_CLOSED);
    send_request(ACT_RESTART + 3'd3, 16'd0, HOLD_NONE);
    send_request(ACT_BLINK, 16'd0, HOLD_NONE);
    send_request(ACT_TICK, 16'd0, HOLD_NONE);
    send_request(ACT_TICK, 16'd33, HOLD_NONE);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    send_request(ACT_TICK, 16'd18, HOLD_NONE);
    send_request(ACT_TICK, 16'd30, HOLD_NONE);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    send_request(ACT_DOUBLE, 16'd0, HOLD_NONE);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    send_request(ACT_BLINK, 16'd0, HOLD_NONE);
    send_request(ACT_HOLD, 16'd0, HOLD_OPEN);
    send_request(ACT_TICK, 16'd5, HOLD_NONE);
    send_request(ACT_BLINK, 16'd0, HOLD_NONE);
    send_request(ACT_DOUBLE, 16'd0, HOLD_NONE);
    send_request(ACT_HOLD, 16'd0, HOLD_CLOSED);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    send_request(ACT_HOLD, 16'd0, HOLD_OPEN | HOLD_CLOSED);
    send_request(ACT_RESTART, 16'd0, HOLD_NONE);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    send_request(ACT_HOLD, 16'd0, HOLD_NONE);

    // low extremes, widest gap range
    configure(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd65535);
    run_random(200);

    // all bits high: rate clamps at the top, duration takes its largest value
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd10, 32'd200);
    run_random(150);

    // manual blinks only, empty gap range
    configure(32'd26, 32'd40, 32'd0, $urandom, 32'd500, 32'd100);
    run_random(150);

    repeat (2) begin
      configure($urandom_range(26, 2560), $urandom_range(40, 400), 32'd1, $urandom,
                $urandom_range(0, 100), $urandom_range(0, 400));
      run_random(150);
    end

    // long idle with automatic blinks off
    quiet = 1'b1;
    configure(32'd0, 32'd150, 32'd0, 32'd0, 32'd65535, 32'd65535);
    for (int i = 0; i < LONG_TICKS; i++)
      send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    wait_idle();
    set_reg(REG_AUTO, 32'd1);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_request(ACT_TICK, 16'd0, HOLD_NONE);
    send_request(ACT_TICK, 16'd10, HOLD_NONE);
    send_request(ACT_TICK, 16'hFFFF, HOLD_NONE);
    quiet = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("eyelid_blink_sequencer_top_tb passed");
    end else begin
      $display("eyelid_blink_sequencer_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ebs_pkg.sv
rtl/core/eyelid_blink_sequencer_top.sv
rtl/core/ebs_checker.sv
sim/eyelid_blink_sequencer_top_tb.sv
